// File: hw/rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, widths and calendar tables
// Command and status structs between controller and datapath, the
// month-length and days-before-month tables, and the leap test.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int YEAR_W      = 14;
    localparam int YCNT_W      = YEAR_W + 1;   // year count may run past 16383
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int OFF_W       = 16;
    localparam int TOTAL_W     = 17;           // up to 334 + 1 + 31 + 65535
    localparam int REM_W       = YEAR_W;       // year mod 400 while being reduced
    localparam int STEP_W      = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [STEP_W-1:0]  MOD_STEP_FIRST = 3'd5;  // 400 << 5 = 12800
    localparam logic [REM_W-1:0]   REM_LAST       = 14'd399;
    localparam logic [MONTH_W-1:0] MONTH_LAST     = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
    localparam logic [TOTAL_W-1:0] DAYS_YEAR      = 17'd365;
    localparam logic [TOTAL_W-1:0] DAYS_LEAP_YEAR = 17'd366;

    typedef struct packed {
        logic load;        // capture the input transfer
        logic mod_step;    // one conditional subtract of 400 << k
        logic sum;         // form the day count from month, day and offset
        logic year_step;   // take off one whole year
        logic month_step;  // take off one whole month
        logic out_load;    // move the finished date to the result register
    } cmd_t;

    typedef struct packed {
        logic mod_last;    // the current reduction step is the final one
        logic year_more;   // day count still exceeds the current year
        logic month_more;  // day count still exceeds the current month
    } sts_t;

    // 400 shifted left by the step index
    function automatic logic [REM_W-1:0] mod_const(input logic [STEP_W-1:0] k);
        logic [REM_W-1:0] c;
        case (k)
            3'd0:    c = 14'd400;
            3'd1:    c = 14'd800;
            3'd2:    c = 14'd1600;
            3'd3:    c = 14'd3200;
            3'd4:    c = 14'd6400;
            3'd5:    c = 14'd12800;
            default: c = 14'd400;
        endcase
        return c;
    endfunction

    // leap test on the year taken mod 400
    function automatic logic is_leap(input logic [REM_W-1:0] r);
        return (r[1:0] == 2'd0) && (r != 14'd100) && (r != 14'd200) && (r != 14'd300);
    endfunction

    function automatic logic [TOTAL_W-1:0] month_len(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [TOTAL_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 17'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 17'd30;
            4'd2:    d = leap ? 17'd29 : 17'd28;
            default: d = 17'd0;
        endcase
        return d;
    endfunction

    // days in the months before m of a common year; m is already clamped to 12
    function automatic logic [TOTAL_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [TOTAL_W-1:0] d;
        case (m)
            4'd2:    d = 17'd31;
            4'd3:    d = 17'd59;
            4'd4:    d = 17'd90;
            4'd5:    d = 17'd120;
            4'd6:    d = 17'd151;
            4'd7:    d = 17'd181;
            4'd8:    d = 17'd212;
            4'd9:    d = 17'd243;
            4'd10:   d = 17'd273;
            4'd11:   d = 17'd304;
            4'd12:   d = 17'd334;
            default: d = 17'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days: gregorian date plus a day offset
// Adds a non-negative day offset to a start date and returns the later date.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields (tdata, lowest bit first)
//  -------  ---  ----------------------------------------------------------
//  s_       in   start_year[13:0] start_month[17:14] start_day[22:18]
//                offset_days[38:23], bit 39 zero
//  m_       out  result_year[13:0] result_month[17:14] result_day[22:18],
//                bit 23 zero
//
//  from input transfer to the result register, an item passes through six
//  steps that reduce the year mod 400, one that forms the day count, Y year
//  steps, where Y is the number of whole years taken off (up to about 180),
//  M month steps for the whole months (up to 11), one exit test for each loop
//  and one step that loads the result; the controller then returns to idle
//  and takes the next input transfer only there, while no item is in flight
//  aresetn is synchronous and clears the controller and the result valid
//  a stalled result holds in its register; the next input transfer is taken
//  while it waits, but the loaded item finishes only once it is gone
//
module gregorian_date_add_days (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_year, start_month, start_day, offset_days, zero pad
    input  logic [gda_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_year, result_month, result_day, zero pad
    output logic [gda_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // command and status between controller and datapath
    gda_pkg::cmd_t cmd;
    gda_pkg::sts_t sts;

    // sequencing, handshakes and result valid
    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // year count, mod-400 leap tracking, day count and result register
    gda_dpath u_dpath (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule

// File: hw/rtl/gda_dpath.sv
// ----------------------------------------------------------------------------
// gda_dpath: date arithmetic datapath
// Holds the year count, year mod 400, month and day count, reduces the year
// mod 400 and steps one year or month per command; holds the result register.
// ----------------------------------------------------------------------------
module gda_dpath (
    input  logic                              aclk,
    input  logic [gda_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  gda_pkg::cmd_t                     cmd,
    output gda_pkg::sts_t                     sts,
    output logic [gda_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    logic [gda_pkg::YCNT_W-1:0]   year_reg,  year_next;
    logic [gda_pkg::REM_W-1:0]    rem_reg,   rem_next;
    logic [gda_pkg::STEP_W-1:0]   k_reg,     k_next;
    logic [gda_pkg::MONTH_W-1:0]  month_reg, month_next;
    logic [gda_pkg::DAY_W-1:0]    day_reg,   day_next;
    logic [gda_pkg::OFF_W-1:0]    off_reg,   off_next;
    logic [gda_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [gda_pkg::OUT_TDATA_W-1:0] res_reg, res_next;

    logic [gda_pkg::YEAR_W-1:0]   in_year;
    logic [gda_pkg::MONTH_W-1:0]  in_month;
    logic [gda_pkg::REM_W-1:0]    mc;
    logic                         leap;
    logic [gda_pkg::TOTAL_W-1:0]  ylen;
    logic [gda_pkg::TOTAL_W-1:0]  mlen;
    logic [gda_pkg::TOTAL_W-1:0]  sum_days;

    assign in_year  = s_tdata[13:0];
    assign in_month = (s_tdata[17:14] > gda_pkg::MONTH_LAST) ? gda_pkg::MONTH_LAST
                                                             : s_tdata[17:14];

    assign mc   = gda_pkg::mod_const(k_reg);
    assign leap = gda_pkg::is_leap(rem_reg);
    assign ylen = leap ? gda_pkg::DAYS_LEAP_YEAR : gda_pkg::DAYS_YEAR;
    assign mlen = gda_pkg::month_len(leap, month_reg);

    assign sum_days = gda_pkg::days_before(month_reg)
                    + {16'd0, (leap && (month_reg > 4'd2))}
                    + {12'd0, day_reg}
                    + {1'b0, off_reg};

    assign sts.mod_last   = (k_reg == '0);
    assign sts.year_more  = (total_reg > ylen);
    assign sts.month_more = (month_reg < gda_pkg::MONTH_LAST) && (total_reg > mlen);

    always_comb begin
        year_next  = year_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        month_next = month_reg;
        day_next   = day_reg;
        off_next   = off_reg;
        total_next = total_reg;
        res_next   = res_reg;
        if (cmd.load) begin
            year_next  = {1'b0, in_year};
            rem_next   = in_year;
            k_next     = gda_pkg::MOD_STEP_FIRST;
            month_next = in_month;
            day_next   = s_tdata[22:18];
            off_next   = s_tdata[38:23];
        end
        if (cmd.mod_step) begin
            if (rem_reg >= mc) begin
                rem_next = rem_reg - mc;
            end
            k_next = k_reg - 3'd1;
        end
        if (cmd.sum) begin
            total_next = sum_days;
            month_next = gda_pkg::MONTH_FIRST;
        end
        if (cmd.year_step) begin
            total_next = total_reg - ylen;
            year_next  = year_reg + 15'd1;
            rem_next   = (rem_reg == gda_pkg::REM_LAST) ? '0 : rem_reg + 14'd1;
        end
        if (cmd.month_step) begin
            total_next = total_reg - mlen;
            month_next = month_reg + 4'd1;
        end
        if (cmd.out_load) begin
            res_next = {1'b0, total_reg[gda_pkg::DAY_W-1:0], month_reg,
                        year_reg[gda_pkg::YEAR_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        year_reg  <= year_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        off_reg   <= off_next;
        total_reg <= total_next;
        res_reg   <= res_next;
    end

    assign m_tdata = res_reg;

endmodule

// File: hw/rtl/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl: sequencing controller
// Walks one item through mod-400 reduction, day sum, year and month loops,
// and owns the handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module gda_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  gda_pkg::sts_t sts,
    output gda_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_YEAR  = 3'd3;
    localparam logic [2:0] ST_MONTH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_YEAR;
            end
            ST_YEAR: begin
                if (sts.year_more) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (sts.month_more) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// File: hw/rtl/gda_checker.sv
// ----------------------------------------------------------------------------
// gda_checker: port-level checks for the date adder
// Watches the top-level ports and flags handshake and result-range slips.
// ----------------------------------------------------------------------------
module gda_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [gda_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // result valid comes up cleared after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid set after reset");

    // a stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: no input transfer right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // result month always lands in 1..12 and the pad bit stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12)
                     && (m_tdata[23] == 1'b0))
        else $error("result month out of range");

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
